@@ rtl/utf8_to_utf16_stream_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder assertion macros
// Shared assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_STREAM_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define U8U16_ASSERT_NOW(lbl, clk, rstn, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (cons)) \
    else $error("u8u16 assertion failed");
// Next-cycle implication, disabled during reset.
`define U8U16_ASSERT_NEXT(lbl, clk, rstn, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (cons)) \
    else $error("u8u16 assertion failed");
`else
`define U8U16_ASSERT_NOW(lbl, clk, rstn, ant, cons)
`define U8U16_ASSERT_NEXT(lbl, clk, rstn, ant, cons)
`endif

`endif

@@ rtl/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg
// Item types, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Input item opcodes.
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // UTF-16 constants.
  localparam logic [15:0] U_REPL    = 16'hFFFD;
  localparam logic [15:0] U_HI_BASE = 16'hD800;
  localparam logic [15:0] U_LO_BASE = 16'hDC00;
  localparam logic [20:0] U_PLANE1  = 21'h10000;

  // Flush feeds the UTF-8 form of the replacement character.
  localparam logic [7:0] FL_B0 = 8'hEF;
  localparam logic [7:0] FL_B1 = 8'hBF;
  localparam logic [7:0] FL_B2 = 8'hBD;

  // Limit on code units per input item.
  localparam logic [2:0] MAX_UNITS = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last;
  } out_item_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // take the input item into the work buffer
    logic step;       // decode one sequence at the buffer front
    logic emit_next;  // move to the next collected code unit
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic len_zero;   // work buffer is empty
    logic held_zero;  // no bytes held from earlier items
    logic ucnt_zero;  // no code units collected
    logic last_unit;  // current code unit is the final one
  } dp_sts_t;

endpackage

@@ rtl/u8u16_datapath.sv @@
// ----------------------------------------------------------------------------
// u8u16_datapath
// Work buffer, held-byte store, one-sequence decoder and code unit buffer.
// ----------------------------------------------------------------------------
module u8u16_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  u8u16_pkg::in_item_t    in_data,
  input  u8u16_pkg::dp_cmd_t     cmd,
  output u8u16_pkg::dp_sts_t     sts,
  output u8u16_pkg::out_item_t   out_data
);

  // Work buffer: byte 0 is the decode front.
  logic [5:0][7:0]  buf_r, buf_nxt;
  logic [2:0]       len_r, len_nxt;
  logic             flush_r;
  // Bytes of an incomplete sequence carried to the next item.
  logic [2:0][7:0]  held_r;
  logic [1:0]       hcnt_r;
  // Collected code units of the current item.
  logic [3:0][15:0] unit_r;
  logic [2:0]       ucnt_r, ucnt_nxt;
  logic [1:0]       optr_r;

  logic [7:0]       b0, b1, b2, b3;
  logic             is_ascii, is_two, is_three, is_four, is_multi;
  logic [2:0]       need;
  logic             incomplete, cont_ok;
  logic [20:0]      cp, wv;
  logic [2:0]       adv, nu;
  logic [15:0]      u0, u1;
  logic [47:0]      extra_vec, held_vec, load_vec;
  logic [2:0]       load_len;
  logic [2:0]       usum;

  // Decode of the sequence at the buffer front.
  always_comb begin
    b0 = buf_r[0];
    b1 = buf_r[1];
    b2 = buf_r[2];
    b3 = buf_r[3];
    is_ascii = (b0[7] == 1'b0);
    is_two   = (b0[7:5] == 3'b110);
    is_three = (b0[7:4] == 4'b1110);
    is_four  = (b0[7:3] == 5'b11110);
    is_multi = is_two | is_three | is_four;
    need = is_four ? 3'd4 : (is_three ? 3'd3 : (is_two ? 3'd2 : 3'd1));
    incomplete = is_multi && (len_r < need);
    cont_ok = (b1[7:6] == 2'b10)
            && ((need < 3'd3) || (b2[7:6] == 2'b10))
            && ((need < 3'd4) || (b3[7:6] == 2'b10));
    priority if (is_two) begin
      cp = {10'd0, b0[4:0], b1[5:0]};
    end else if (is_three) begin
      cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
    end else begin
      cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    end
    if (is_ascii) begin
      cp = {13'd0, b0};
    end
    if (!(is_ascii || (is_multi && cont_ok))) begin
      cp = {5'd0, u8u16_pkg::U_REPL};
    end
    adv = (is_multi && cont_ok) ? need : 3'd1;

    // Map the code point to one or two code units.
    wv = cp - u8u16_pkg::U_PLANE1;
    if (|cp[20:16]) begin
      nu = 3'd2;
      u0 = u8u16_pkg::U_HI_BASE + {5'd0, wv[20:10]};
      u1 = u8u16_pkg::U_LO_BASE + {6'd0, wv[9:0]};
    end else begin
      nu = 3'd1;
      u0 = (cp[15:11] == 5'b11011) ? u8u16_pkg::U_REPL : cp[15:0];
      u1 = u8u16_pkg::U_REPL;
    end
    usum = ucnt_r + nu;
    ucnt_nxt = (usum > u8u16_pkg::MAX_UNITS) ? u8u16_pkg::MAX_UNITS : usum;

    // Drop the consumed bytes from the front.
    buf_nxt = buf_r >> {adv, 3'b000};
    len_nxt = len_r - adv;
  end

  // New work buffer: held bytes, then the byte or the flush bytes.
  always_comb begin
    if (in_data.opcode == u8u16_pkg::OP_FLUSH) begin
      extra_vec = {24'd0, u8u16_pkg::FL_B2, u8u16_pkg::FL_B1, u8u16_pkg::FL_B0};
      load_len  = {1'b0, hcnt_r} + 3'd3;
    end else begin
      extra_vec = {40'd0, in_data.data_byte};
      load_len  = {1'b0, hcnt_r} + 3'd1;
    end
    held_vec = '0;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(hcnt_r)) begin
        held_vec[i*8 +: 8] = held_r[i];
      end
    end
    load_vec = (extra_vec << {hcnt_r, 3'b000}) | held_vec;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 3'd0;
      hcnt_r  <= 2'd0;
      ucnt_r  <= 3'd0;
      optr_r  <= 2'd0;
      flush_r <= 1'b0;
    end else if (cmd.load) begin
      len_r   <= load_len;
      hcnt_r  <= 2'd0;
      ucnt_r  <= 3'd0;
      optr_r  <= 2'd0;
      flush_r <= (in_data.opcode == u8u16_pkg::OP_FLUSH);
    end else if (cmd.step) begin
      if (incomplete) begin
        len_r <= 3'd0;
        if (!flush_r) begin
          hcnt_r <= len_r[1:0];
        end
      end else begin
        len_r  <= len_nxt;
        ucnt_r <= ucnt_nxt;
      end
    end else if (cmd.emit_next) begin
      optr_r <= optr_r + 2'd1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_r <= load_vec;
    end else if (cmd.step) begin
      if (incomplete) begin
        held_r <= buf_r[2:0];
      end else begin
        buf_r <= buf_nxt;
        if (ucnt_r < u8u16_pkg::MAX_UNITS) begin
          unit_r[ucnt_r[1:0]] <= u0;
        end
        if ((nu == 3'd2) && (ucnt_r < u8u16_pkg::MAX_UNITS - 3'd1)) begin
          unit_r[ucnt_r[1:0] + 2'd1] <= u1;
        end
      end
    end
  end

  // Status and result item.
  always_comb begin
    sts.len_zero  = (len_r == 3'd0);
    sts.held_zero = (hcnt_r == 2'd0);
    sts.ucnt_zero = (ucnt_r == 3'd0);
    sts.last_unit = (({1'b0, optr_r} + 3'd1) == ucnt_r);
    out_data.code_unit = unit_r[optr_r];
    out_data.last      = sts.last_unit;
  end

endmodule

@@ rtl/u8u16_ctrl.sv @@
// ----------------------------------------------------------------------------
// u8u16_ctrl
// Controller: accepts an item, runs decode steps, then hands out code units.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_stream_decoder_macros.svh"

module u8u16_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_flush,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  u8u16_pkg::dp_sts_t   sts,
  output u8u16_pkg::dp_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_fire, out_fire;

  // Handshakes and commands.
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    out_valid     = (state_r == S_EMIT);
    in_fire       = in_valid && in_ready;
    out_fire      = out_valid && out_ready;
    cmd.load      = in_fire && !(in_flush && sts.held_zero);
    cmd.step      = (state_r == S_DECODE) && !sts.len_zero;
    cmd.emit_next = out_fire && !sts.last_unit;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.len_zero) begin
          state_nxt = sts.ucnt_zero ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_fire && sts.last_unit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks on the sequencing.
  `U8U16_ASSERT_NOW(a_emit_has_units, clk, rst_n, state_r == S_EMIT, !sts.ucnt_zero)
  `U8U16_ASSERT_NEXT(a_load_decodes, clk, rst_n, cmd.load, state_r == S_DECODE)
  `U8U16_ASSERT_NEXT(a_last_ends_item, clk, rst_n, out_fire && sts.last_unit, state_r == S_IDLE)

endmodule

@@ rtl/utf8_to_utf16_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// Streaming UTF-8 to UTF-16 transcoder, one item in, up to four code units out.
// ----------------------------------------------------------------------------
// The block works on one item at a time. An accepted item is loaded into the
// work buffer and decoded one sequence per cycle (at most six for a flush);
// once the buffer is empty, the code units are handed out one per cycle while
// the output side is ready. A byte that only extends a held sequence produces
// nothing, and neither does a flush with nothing held.
// The final code unit of an item carries last.
module utf8_to_utf16_stream_decoder (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  u8u16_pkg::in_item_t    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output u8u16_pkg::out_item_t   out_data
);

  u8u16_pkg::dp_cmd_t cmd;
  u8u16_pkg::dp_sts_t sts;

  // Sequencing.
  u8u16_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_flush  (in_data.opcode == u8u16_pkg::OP_FLUSH),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Buffers and decoder.
  u8u16_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
